[rtl/lbr_pkg.sv]
// Shared types and codes for the line Bresenham rasteriser.
// No dependencies; used by scoped name by lbr_in_stage, lbr_step_core and the top.
`timescale 1ns / 1ps
`default_nettype none

package lbr_pkg;

  // Item kinds carried on the slave tuser bit
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Control of the item held in the input register
  typedef struct packed {
    logic valid;
    logic op;
  } item_ctrl_t;

endpackage

`default_nettype wire

[rtl/lbr_in_stage.sv]
// Input register of the line Bresenham rasteriser.
// Depends on lbr_pkg for the item control struct.
`timescale 1ns / 1ps
`default_nettype none

module lbr_in_stage #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic                  s_op,
  input  wire logic [COORD_BITS-1:0] s_start_x,
  input  wire logic [COORD_BITS-1:0] s_start_y,
  input  wire logic [COORD_BITS-1:0] s_end_x,
  input  wire logic [COORD_BITS-1:0] s_end_y,
  input  wire logic                  advance,
  output lbr_pkg::item_ctrl_t        item_ctrl,
  output logic [COORD_BITS-1:0]      item_start_x,
  output logic [COORD_BITS-1:0]      item_start_y,
  output logic [COORD_BITS-1:0]      item_end_x,
  output logic [COORD_BITS-1:0]      item_end_y
);

  logic held_valid;
  logic held_op;

  // Take a new item whenever the held one is empty or moves on this cycle
  assign s_tready = !held_valid || advance;

  // Hold the control of the buffered item
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (s_tready) begin
      held_valid <= s_tvalid;
    end
  end

  // Capture the payload on each transfer
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      held_op      <= s_op;
      item_start_x <= s_start_x;
      item_start_y <= s_start_y;
      item_end_x   <= s_end_x;
      item_end_y   <= s_end_y;
    end
  end

  assign item_ctrl.valid = held_valid;
  assign item_ctrl.op    = held_op;

endmodule

`default_nettype wire

[rtl/lbr_step_core.sv]
// Line state, set-up and step arithmetic, and result register.
// Depends on lbr_pkg for the item control struct and op codes.
`timescale 1ns / 1ps
`default_nettype none

module lbr_step_core #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire lbr_pkg::item_ctrl_t   item_ctrl,
  input  wire logic [COORD_BITS-1:0] item_start_x,
  input  wire logic [COORD_BITS-1:0] item_start_y,
  input  wire logic [COORD_BITS-1:0] item_end_x,
  input  wire logic [COORD_BITS-1:0] item_end_y,
  output logic                       advance,
  output logic                       res_valid,
  input  wire logic                  res_ready,
  output logic [COORD_BITS-1:0]      res_x,
  output logic [COORD_BITS-1:0]      res_y,
  output logic                       res_pixel_valid,
  output logic                       res_last
);

  localparam int C  = COORD_BITS;
  localparam int IW = C + 2;  // increments
  localparam int EW = C + 3;  // error term

  // Line state
  logic                 line_active, line_active_next;
  logic [C-1:0]         cursor_x, cursor_x_next;
  logic [C-1:0]         cursor_y, cursor_y_next;
  logic [C-1:0]         major_end, major_end_next;
  logic signed [EW-1:0] error_term, error_term_next;
  logic signed [IW-1:0] plain_increment, plain_increment_next;
  logic signed [IW-1:0] diagonal_increment, diagonal_increment_next;
  logic                 minor_step_negative, minor_step_negative_next;
  logic                 walk_along_y, walk_along_y_next;

  // Result fields before the result register
  logic [C-1:0] out_x, out_y;
  logic         out_pixel_valid, out_last;

  // Set-up and step intermediates
  logic [C-1:0] dx, dy, maj_d, min_d;
  logic         y_major;
  logic [C-1:0] start_major;
  logic         err_positive;
  logic [C-1:0] major_now, minor_now, major_stepped, minor_stepped;
  logic         fire;

  // Result register moves when empty or taken downstream
  assign advance = !res_valid || res_ready;
  assign fire    = item_ctrl.valid && advance;

  // Set-up: deltas and choice of major axis
  always_comb begin
    dx      = (item_start_x > item_end_x) ? item_start_x - item_end_x
                                          : item_end_x - item_start_x;
    dy      = (item_start_y > item_end_y) ? item_start_y - item_end_y
                                          : item_end_y - item_start_y;
    y_major = dy > dx;
    maj_d   = y_major ? dy : dx;
    min_d   = y_major ? dx : dy;
  end

  // Step: pick the current major and minor coordinates
  always_comb begin
    err_positive  = !error_term[EW-1] && (error_term != '0);
    major_now     = walk_along_y ? cursor_y : cursor_x;
    minor_now     = walk_along_y ? cursor_x : cursor_y;
    major_stepped = major_now + C'(1);
    if (!err_positive) begin
      minor_stepped = minor_now;
    end else if (minor_step_negative) begin
      minor_stepped = minor_now - C'(1);
    end else begin
      minor_stepped = minor_now + C'(1);
    end
  end

  // Next state and result for the item held in the input register
  always_comb begin
    line_active_next         = line_active;
    cursor_x_next            = cursor_x;
    cursor_y_next            = cursor_y;
    major_end_next           = major_end;
    error_term_next          = error_term;
    plain_increment_next     = plain_increment;
    diagonal_increment_next  = diagonal_increment;
    minor_step_negative_next = minor_step_negative;
    walk_along_y_next        = walk_along_y;
    start_major              = '0;
    out_x                    = '0;
    out_y                    = '0;
    out_pixel_valid          = 1'b0;
    out_last                 = 1'b0;

    case (item_ctrl.op)
      lbr_pkg::OP_START: begin
        walk_along_y_next       = y_major;
        plain_increment_next    = {1'b0, min_d, 1'b0};
        diagonal_increment_next = {1'b0, min_d, 1'b0} - {1'b0, maj_d, 1'b0};
        error_term_next         = {2'b00, min_d, 1'b0} - {3'b000, maj_d};
        if (y_major) begin
          if (item_start_y < item_end_y) begin
            cursor_x_next            = item_start_x;
            cursor_y_next            = item_start_y;
            major_end_next           = item_end_y;
            minor_step_negative_next = !(item_start_x < item_end_x);
          end else begin
            cursor_x_next            = item_end_x;
            cursor_y_next            = item_end_y;
            major_end_next           = item_start_y;
            minor_step_negative_next = !(item_start_x > item_end_x);
          end
          start_major = cursor_y_next;
        end else begin
          if (item_start_x < item_end_x) begin
            cursor_x_next            = item_start_x;
            cursor_y_next            = item_start_y;
            major_end_next           = item_end_x;
            minor_step_negative_next = !(item_start_y < item_end_y);
          end else begin
            cursor_x_next            = item_end_x;
            cursor_y_next            = item_end_y;
            major_end_next           = item_start_x;
            minor_step_negative_next = !(item_start_y > item_end_y);
          end
          start_major = cursor_x_next;
        end
        line_active_next = start_major != major_end_next;
        out_x            = cursor_x_next;
        out_y            = cursor_y_next;
        out_pixel_valid  = 1'b1;
        out_last         = !line_active_next;
      end
      lbr_pkg::OP_STEP: begin
        // Idle step leaves the state alone and reports an empty pixel
        if (line_active) begin
          if (err_positive) begin
            error_term_next = error_term + {diagonal_increment[IW-1], diagonal_increment};
          end else begin
            error_term_next = error_term + {plain_increment[IW-1], plain_increment};
          end
          if (walk_along_y) begin
            cursor_y_next = major_stepped;
            cursor_x_next = minor_stepped;
          end else begin
            cursor_x_next = major_stepped;
            cursor_y_next = minor_stepped;
          end
          line_active_next = major_stepped != major_end;
          out_x            = cursor_x_next;
          out_y            = cursor_y_next;
          out_pixel_valid  = 1'b1;
          out_last         = !line_active_next;
        end
      end
      default: begin
        out_pixel_valid = 1'b0;
      end
    endcase
  end

  // Commit line state when the held item moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      line_active         <= 1'b0;
      cursor_x            <= '0;
      cursor_y            <= '0;
      major_end           <= '0;
      error_term          <= '0;
      plain_increment     <= '0;
      diagonal_increment  <= '0;
      minor_step_negative <= 1'b0;
      walk_along_y        <= 1'b0;
    end else if (fire) begin
      line_active         <= line_active_next;
      cursor_x            <= cursor_x_next;
      cursor_y            <= cursor_y_next;
      major_end           <= major_end_next;
      error_term          <= error_term_next;
      plain_increment     <= plain_increment_next;
      diagonal_increment  <= diagonal_increment_next;
      minor_step_negative <= minor_step_negative_next;
      walk_along_y        <= walk_along_y_next;
    end
  end

  // Result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= item_ctrl.valid;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (fire) begin
      res_x           <= out_x;
      res_y           <= out_y;
      res_pixel_valid <= out_pixel_valid;
      res_last        <= out_last;
    end
  end

endmodule

`default_nettype wire

[rtl/line_bresenham_rasterizer.sv]
// Top level of the line Bresenham rasteriser: stream ports and packing.
// Depends on lbr_pkg, lbr_in_stage and lbr_step_core.
`timescale 1ns / 1ps
`default_nettype none

// Bresenham line stepper. A start item (tuser 0) carries both endpoints and
// returns the first pixel of the line; each step item (tuser 1) returns the
// next pixel, with tlast on the final point. A step with no line in progress
// returns a result with tuser 0 and zero data. Exactly one result per item,
// in order. Throughput is one item per clock while m_tready does not stall
// the result register: the set-up and the error-term add and compare sit
// between the input register and the result register, and m_tvalid rises
// once the item moves from the input register into the result register.
// Line state updates as an item enters the result register, so back-to-back steps chain without bubbles.
module line_bresenham_rasterizer #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // start_x, start_y, end_x, end_y from bit 0 up, zero padded to bytes
  input  wire logic [((4*COORD_BITS+7)/8)*8-1:0] s_tdata,
  // op
  input  wire logic                  s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // pixel_x, pixel_y from bit 0 up, zero padded to bytes
  output logic [((2*COORD_BITS+7)/8)*8-1:0] m_tdata,
  // pixel_valid
  output logic                       m_tuser,
  // last_pixel
  output logic                       m_tlast
);

  localparam int C     = COORD_BITS;
  localparam int OUT_W = ((2*C+7)/8)*8;

  lbr_pkg::item_ctrl_t item_ctrl;
  logic [C-1:0] item_start_x, item_start_y, item_end_x, item_end_y;
  logic [C-1:0] res_x, res_y;
  logic         advance;

  lbr_in_stage #(.COORD_BITS(C)) u_in_stage (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_op         (s_tuser),
    .s_start_x    (s_tdata[C-1:0]),
    .s_start_y    (s_tdata[2*C-1:C]),
    .s_end_x      (s_tdata[3*C-1:2*C]),
    .s_end_y      (s_tdata[4*C-1:3*C]),
    .advance      (advance),
    .item_ctrl    (item_ctrl),
    .item_start_x (item_start_x),
    .item_start_y (item_start_y),
    .item_end_x   (item_end_x),
    .item_end_y   (item_end_y)
  );

  lbr_step_core #(.COORD_BITS(C)) u_step_core (
    .clk             (clk),
    .rst             (rst),
    .item_ctrl       (item_ctrl),
    .item_start_x    (item_start_x),
    .item_start_y    (item_start_y),
    .item_end_x      (item_end_x),
    .item_end_y      (item_end_y),
    .advance         (advance),
    .res_valid       (m_tvalid),
    .res_ready       (m_tready),
    .res_x           (res_x),
    .res_y           (res_y),
    .res_pixel_valid (m_tuser),
    .res_last        (m_tlast)
  );

  // Pack the pixel coordinates, zero fill to whole bytes
  assign m_tdata = OUT_W'({res_y, res_x});

endmodule

`default_nettype wire

[rtl/lbr_checker.sv]
// Port-level checks for the line Bresenham rasteriser, bound to the top.
// Depends on line_bresenham_rasterizer port names and its COORD_BITS parameter only.
`timescale 1ns / 1ps
`default_nettype none

module lbr_checker #(
  parameter int COORD_BITS = 12
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_tvalid,
  input wire logic                  s_tready,
  input wire logic [((4*COORD_BITS+7)/8)*8-1:0] s_tdata,
  input wire logic                  s_tuser,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [((2*COORD_BITS+7)/8)*8-1:0] m_tdata,
  input wire logic                  m_tuser,
  input wire logic                  m_tlast
);

  // A stalled input holds until its transfer
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
    else $error("stalled input changed");

  // A stalled result holds until its transfer
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

  // The final point of a line is always a real pixel
  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser)
    else $error("last flag on an empty result");

  // An empty result carries zero coordinates
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("empty result with non-zero data");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind line_bresenham_rasterizer lbr_checker #(.COORD_BITS(COORD_BITS)) u_lbr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire
